>>> rtl/esa_pkg.sv
// esa_pkg: shared types and constants for the encoder speed averager
// no dependencies
package esa_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 4;
  localparam logic [15:0] CPR_RESET = 16'd4096;
  localparam logic [13:0] SPS_RESET = 14'd200;
  localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;

  // configuration register indexes
  localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [1:0] REG_CPR_A = 2'd1;
  localparam logic [1:0] REG_CPR_B = 2'd2;
  localparam logic [1:0] REG_SPS = 2'd3;

  // start command from the controller to each lane
  typedef struct packed {
    logic        start;
    logic [15:0] cpr;
    logic [13:0] sps;
  } lane_cmd_t;

  // lane status back to the merge stage
  typedef struct packed {
    logic        done;
    logic [15:0] rpm;
  } lane_sts_t;

endpackage

>>> rtl/esa_lane.sv
// esa_lane: one wheel's delta, history ring, mean and rpm divider
// depends on esa_pkg
module esa_lane
  import esa_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic        sample,
  input  logic [15:0] count,
  input  logic        down,
  input  logic        wrapped,
  input  logic [15:0] cpr,
  input  lane_cmd_t   cmd,
  output logic [15:0] delta,
  output lane_sts_t   sts
);

  localparam int unsigned SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SUMW = 16 + SW + 1;
  localparam int unsigned PW = SUMW + 20;
  localparam logic [SW:0] DEPTH_M1 = (SW + 1)'(HISTORY_DEPTH - 1);
  localparam logic [6:0] DIV_STEPS = 7'(PW);
  // reciprocal of the depth, exact for any sum magnitude below 2^SUMW
  localparam int unsigned MSH = SUMW + SW;
  localparam logic [MSH:0] MEAN_RECIP =
    (MSH + 1)'(((64'd1 << MSH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  typedef enum logic [2:0] {S_IDLE, S_SUM, S_MEAN, S_MUL, S_DIV, S_DONE} st_t;

  st_t st;
  logic [15:0] prev_count;
  logic [15:0] wrap_total;
  logic        first_sample;
  logic [15:0] hist [HISTORY_DEPTH];
  logic [SW-1:0] slot;
  logic [SW:0]   idx;
  logic signed [SUMW-1:0] sum;
  logic signed [SUMW-1:0] mean;
  logic        neg;
  logic [PW-1:0] quo;
  logic [16:0]   rem;
  logic [6:0]    steps;
  logic [15:0] dcpr;
  logic [13:0] dsps;
  logic [15:0] rpm;
  logic        done;

  logic [15:0] wrap_now;
  logic [31:0] weight;
  logic [15:0] diff;
  logic [15:0] delta_next;
  logic [15:0] mag;
  logic [16:0] rem_sh;
  logic [SW-1:0] slot_next;
  logic [SUMW-1:0] sum_mag;
  logic [SUMW+MSH:0] mean_prod;

  // wrap total including this tick's flag
  assign wrap_now = (wrapped && wrap_total != 16'hFFFF) ? wrap_total + 16'd1 : wrap_total;
  assign weight = wrap_now * cpr;
  assign diff = count - prev_count;
  assign delta_next = first_sample ? 16'd0 :
                      (down ? weight[15:0] - diff : weight[15:0] + diff);
  assign mag = mean[SUMW-1] ? 16'(-mean) : 16'(mean);
  assign rem_sh = {rem[15:0], quo[PW-1]};
  assign slot_next = (SW'(slot) == DEPTH_M1[SW-1:0]) ? '0 : slot + SW'(1);

  // magnitude of the history sum scaled by the depth reciprocal
  assign sum_mag = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
  assign mean_prod = (SUMW + MSH + 1)'(sum_mag) * (SUMW + MSH + 1)'(MEAN_RECIP);

  // sample bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count <= '0;
      wrap_total <= '0;
      first_sample <= 1'b1;
      slot <= '0;
      delta <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] <= '0;
    end else if (tick) begin
      if (sample) begin
        wrap_total <= '0;
        prev_count <= count;
        first_sample <= 1'b0;
        delta <= delta_next;
        hist[slot] <= delta_next;
        slot <= (HISTORY_DEPTH > 1) ? slot_next : '0;
      end else begin
        wrap_total <= wrap_now;
      end
    end
  end

  // sum, mean, product, restoring divide
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (cmd.start) begin
            dcpr <= cmd.cpr;
            dsps <= cmd.sps;
            sum <= '0;
            idx <= '0;
            st <= S_SUM;
          end
        end
        S_SUM: begin
          sum <= sum + SUMW'($signed(hist[idx[SW-1:0]]));
          if (idx == DEPTH_M1) st <= S_MEAN;
          idx <= idx + 1'b1;
        end
        S_MEAN: begin
          // truncated toward zero
          mean <= sum[SUMW-1] ? -mean_prod[MSH +: SUMW] : mean_prod[MSH +: SUMW];
          st <= S_MUL;
        end
        S_MUL: begin
          neg <= mean[SUMW-1];
          quo <= PW'(32'(mag) * 32'(dsps)) * PW'(SECONDS_PER_MINUTE);
          rem <= '0;
          steps <= DIV_STEPS;
          st <= (dcpr == 16'd0) ? S_DONE : S_DIV;
          if (dcpr == 16'd0) rpm <= '0;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, dcpr}) begin
            rem <= rem_sh - {1'b0, dcpr};
            quo <= {quo[PW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[PW-2:0], 1'b0};
          end
          steps <= steps - 7'd1;
          if (steps == 7'd1) st <= S_DONE;
        end
        S_DONE: begin
          if (dcpr != 16'd0) rpm <= neg ? -quo[15:0] : quo[15:0];
          done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign sts = '{done: done, rpm: rpm};

endmodule

>>> rtl/encoder_speed_averager.sv
// encoder_speed_averager: top level with countdown, two lanes and result merge
// depends on esa_pkg and esa_lane
//
// channel   direction  handshake      payload
// in        input      valid/stall    count_a count_b down_a down_b wrapped_a wrapped_b
// out       output     valid/stall    delta_a delta_b rpm_a rpm_b
// cfg       input      valid/ready    index data
//
// a tick that is not a sample is taken without stalling and gives no result.
// a sample tick raises out_valid after the serial history sum, mean and product
// steps, then the bit-serial divider in each lane; zero counts per revolution
// skips the divider.
// reset (rst, synchronous) restores register defaults and clears all history.
// a held result parks in the output register; the next item is taken only once it is gone.
module encoder_speed_averager
  import esa_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] count_a,
  input  logic [15:0] count_b,
  input  logic        down_a,
  input  logic        down_b,
  input  logic        wrapped_a,
  input  logic        wrapped_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] delta_a,
  output logic signed [15:0] delta_b,
  output logic signed [15:0] rpm_a,
  output logic signed [15:0] rpm_b,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] sample_interval, cpr_a, cpr_b;
  logic [13:0] sps;
  logic [15:0] countdown;
  logic        busy;
  logic        got_a, got_b;
  logic        tick, sample;
  lane_cmd_t   cmd_a, cmd_b;
  lane_sts_t   sts_a, sts_b;
  logic [15:0] d_a, d_b;

  assign cfg_ready = 1'b1;
  assign in_stall = busy || out_valid;
  assign tick = in_valid && !in_stall;
  assign sample = (countdown == 16'd0);

  assign cmd_a = '{start: tick && sample, cpr: cpr_a, sps: sps};
  assign cmd_b = '{start: tick && sample, cpr: cpr_b, sps: sps};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= '0;
      cpr_a <= CPR_RESET;
      cpr_b <= CPR_RESET;
      sps <= SPS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SAMPLE_INTERVAL: sample_interval <= cfg_data;
        REG_CPR_A: cpr_a <= cfg_data;
        REG_CPR_B: cpr_b <= cfg_data;
        REG_SPS: sps <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // sample countdown and result merge
  always_ff @(posedge clk) begin
    if (rst) begin
      countdown <= '0;
      busy <= 1'b0;
      got_a <= 1'b0;
      got_b <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (tick) begin
        if (sample) begin
          countdown <= sample_interval;
          busy <= 1'b1;
        end else begin
          countdown <= countdown - 16'd1;
        end
      end
      if (sts_a.done) rpm_a <= sts_a.rpm;
      if (sts_b.done) rpm_b <= sts_b.rpm;
      if (busy && (got_a || sts_a.done) && (got_b || sts_b.done)) begin
        busy <= 1'b0;
        got_a <= 1'b0;
        got_b <= 1'b0;
        out_valid <= 1'b1;
        delta_a <= d_a;
        delta_b <= d_b;
      end else begin
        if (sts_a.done) got_a <= 1'b1;
        if (sts_b.done) got_b <= 1'b1;
      end
    end
  end

  esa_lane #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_lane_a (
    .clk(clk), .rst(rst), .tick(tick), .sample(sample),
    .count(count_a), .down(down_a), .wrapped(wrapped_a), .cpr(cpr_a),
    .cmd(cmd_a), .delta(d_a), .sts(sts_a)
  );

  esa_lane #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_lane_b (
    .clk(clk), .rst(rst), .tick(tick), .sample(sample),
    .count(count_b), .down(down_b), .wrapped(wrapped_b), .cpr(cpr_b),
    .cmd(cmd_b), .delta(d_b), .sts(sts_b)
  );

endmodule
